>>> hw/rtl/cdes_pkg.sv
// ----------------------------------------------------------------------------
// cdes_pkg: shared types and constants for the epoch seconds converter
// Word types for both channels, stage word types, error codes and the
// month tables used by the date arithmetic.
// ----------------------------------------------------------------------------
package cdes_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned FieldW  = 7;
  localparam int unsigned SecsW   = 38;
  localparam int unsigned ErrW    = 3;
  localparam int unsigned ProdW   = 27;
  localparam int unsigned DaysW   = 22;
  localparam int unsigned TodW    = 17;
  localparam int unsigned DayMulW = 39;

  localparam logic [YearW-1:0] EPOCH_YEAR = 14'd1970;
  localparam logic [YearW-1:0] LAST_YEAR  = 14'd9999;

  // floor(x / 100) equals (x * DIV100_MUL) >> DIV100_SHIFT for x below 10000.
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;

  // Leap years among 1..1969.
  localparam logic [DaysW-1:0] EPOCH_LEAPS   = 22'd477;
  localparam logic [16:0]      SECS_PER_DAY  = 17'd86400;

  localparam logic [ErrW-1:0] ERR_OK     = 3'd0;
  localparam logic [ErrW-1:0] ERR_YEAR   = 3'd1;
  localparam logic [ErrW-1:0] ERR_MONTH  = 3'd2;
  localparam logic [ErrW-1:0] ERR_DAY    = 3'd3;
  localparam logic [ErrW-1:0] ERR_HOUR   = 3'd4;
  localparam logic [ErrW-1:0] ERR_MINUTE = 3'd5;
  localparam logic [ErrW-1:0] ERR_SECOND = 3'd6;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
  } in_word_t;

  typedef struct packed {
    logic [SecsW-1:0] epoch_seconds;
    logic [ErrW-1:0]  error_code;
  } out_word_t;

  // Word after the range checks and the two year products.
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [FieldW-1:0] month;
    logic [FieldW-1:0] day;
    logic [FieldW-1:0] hour;
    logic [FieldW-1:0] minute;
    logic [FieldW-1:0] second;
    logic [ErrW-1:0]   err_date;
    logic [ErrW-1:0]   err_time;
    logic [ProdW-1:0]  prod_y;
    logic [ProdW-1:0]  prod_y1;
  } chk_word_t;

  // Word after the day count.
  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [TodW-1:0]  tod;
    logic [ErrW-1:0]  err;
  } day_word_t;

  function automatic logic [4:0] month_len(input logic [FieldW-1:0] m);
    logic [4:0] r;
    case (m)
      7'd2:                         r = 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:      r = 5'd30;
      7'd1, 7'd3, 7'd5, 7'd7,
      7'd8, 7'd10, 7'd12:           r = 5'd31;
      default:                      r = 5'd0;
    endcase
    return r;
  endfunction

  // Days in the year before the first day of month m, common year.
  function automatic logic [8:0] month_start(input logic [FieldW-1:0] m);
    logic [8:0] r;
    case (m)
      7'd1:    r = 9'd0;
      7'd2:    r = 9'd31;
      7'd3:    r = 9'd59;
      7'd4:    r = 9'd90;
      7'd5:    r = 9'd120;
      7'd6:    r = 9'd151;
      7'd7:    r = 9'd181;
      7'd8:    r = 9'd212;
      7'd9:    r = 9'd243;
      7'd10:   r = 9'd273;
      7'd11:   r = 9'd304;
      7'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/calendar_date_to_epoch_seconds.sv
// ----------------------------------------------------------------------------
// calendar_date_to_epoch_seconds: UTC calendar fields to Unix epoch seconds
//
//   channel  ports                     direction  handshake
//   input    start, busy, in_word      in         start high, busy low
//   result   out_valid, out_word       out        one-cycle strobe
//
// A new word is accepted in every cycle; busy is always low.
// Each result passes through the check, day count, multiply and final add
// stages, in that order, after its word is accepted.
// Synchronous reset clears the valid bits of all stages.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module calendar_date_to_epoch_seconds (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cdes_pkg::in_word_t  in_word,
  output logic                out_valid,
  output cdes_pkg::out_word_t out_word
);

  logic                chk_vld;
  cdes_pkg::chk_word_t chk_word;
  logic                day_vld;
  cdes_pkg::day_word_t day_word;

  assign busy = 1'b0;

  cdes_check u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_word  (in_word),
    .chk_vld  (chk_vld),
    .chk_word (chk_word)
  );

  cdes_days u_days (
    .clk      (clk),
    .rst_n    (rst_n),
    .chk_vld  (chk_vld),
    .chk_word (chk_word),
    .day_vld  (day_vld),
    .day_word (day_word)
  );

  cdes_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .day_vld  (day_vld),
    .day_word (day_word),
    .out_vld  (out_valid),
    .out_word (out_word)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##4 out_valid)
    else $error("accepted word did not produce a result after four cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 4))
    else $error("result without an accepted word");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.error_code != cdes_pkg::ERR_OK) |-> out_word.epoch_seconds == '0)
    else $error("nonzero seconds on an error result");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.error_code <= cdes_pkg::ERR_SECOND)
    else $error("error code out of range");

  a_year_err: assert property (@(posedge clk) disable iff (!rst_n)
    (start && (in_word.year < cdes_pkg::EPOCH_YEAR || in_word.year > cdes_pkg::LAST_YEAR))
      |-> ##4 out_word.error_code == cdes_pkg::ERR_YEAR)
    else $error("year out of range not reported first");

endmodule

>>> hw/rtl/cdes_check.sv
// ----------------------------------------------------------------------------
// cdes_check: range checks and year products
// First pipeline stage. Checks year, month, hour, minute and second and
// forms the reciprocal products for the division of year and year-1 by 100.
// ----------------------------------------------------------------------------
module cdes_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  cdes_pkg::in_word_t in_word,
  output logic               chk_vld,
  output cdes_pkg::chk_word_t chk_word
);

  logic                vld_r;
  cdes_pkg::chk_word_t word_r;
  cdes_pkg::chk_word_t word_nxt;
  logic [cdes_pkg::YearW-1:0] year_m1;

  always_comb begin
    year_m1  = in_word.year - 14'd1;
    word_nxt.year   = in_word.year;
    word_nxt.month  = in_word.month;
    word_nxt.day    = in_word.day;
    word_nxt.hour   = in_word.hour;
    word_nxt.minute = in_word.minute;
    word_nxt.second = in_word.second;
    if (in_word.year < cdes_pkg::EPOCH_YEAR || in_word.year > cdes_pkg::LAST_YEAR) begin
      word_nxt.err_date = cdes_pkg::ERR_YEAR;
    end else if (in_word.month < 7'd1 || in_word.month > 7'd12) begin
      word_nxt.err_date = cdes_pkg::ERR_MONTH;
    end else begin
      word_nxt.err_date = cdes_pkg::ERR_OK;
    end
    if (in_word.hour > 7'd23) begin
      word_nxt.err_time = cdes_pkg::ERR_HOUR;
    end else if (in_word.minute > 7'd59) begin
      word_nxt.err_time = cdes_pkg::ERR_MINUTE;
    end else if (in_word.second > 7'd60) begin
      word_nxt.err_time = cdes_pkg::ERR_SECOND;
    end else begin
      word_nxt.err_time = cdes_pkg::ERR_OK;
    end
    word_nxt.prod_y  = cdes_pkg::ProdW'({13'd0, in_word.year} * {14'd0, cdes_pkg::DIV100_MUL});
    word_nxt.prod_y1 = cdes_pkg::ProdW'({13'd0, year_m1} * {14'd0, cdes_pkg::DIV100_MUL});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign chk_vld  = vld_r;
  assign chk_word = word_r;

endmodule

>>> hw/rtl/cdes_days.sv
// ----------------------------------------------------------------------------
// cdes_days: leap year, day check and day count
// Second pipeline stage. Derives the leap year flag from the quotients by
// 100, checks the day of month and counts days and seconds of the day.
// ----------------------------------------------------------------------------
module cdes_days (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                chk_vld,
  input  cdes_pkg::chk_word_t chk_word,
  output logic                day_vld,
  output cdes_pkg::day_word_t day_word
);

  logic                vld_r;
  cdes_pkg::day_word_t word_r;
  cdes_pkg::day_word_t word_nxt;
  logic [6:0]  q_y;
  logic [6:0]  q_y1;
  logic [cdes_pkg::YearW-1:0] year_m1;
  logic        div100;
  logic        leap;
  logic [4:0]  mlen;
  logic        day_bad;
  logic [12:0] year_off;
  logic [cdes_pkg::DaysW-1:0] days_years;
  logic [cdes_pkg::DaysW-1:0] days_leaps;
  logic [cdes_pkg::DaysW-1:0] days_month;

  always_comb begin
    q_y     = chk_word.prod_y[cdes_pkg::DIV100_SHIFT +: 7];
    q_y1    = chk_word.prod_y1[cdes_pkg::DIV100_SHIFT +: 7];
    year_m1 = chk_word.year - 14'd1;
    // A year is a multiple of 100 exactly when its quotient differs from
    // that of the year before.
    div100  = (q_y != q_y1);
    leap    = (chk_word.year[1:0] == 2'd0 && !div100) || (div100 && q_y[1:0] == 2'd0);
    mlen    = cdes_pkg::month_len(chk_word.month)
            + {4'd0, (chk_word.month == 7'd2) && leap};
    day_bad = (chk_word.day < 7'd1) || (chk_word.day > {2'd0, mlen});

    if (chk_word.err_date != cdes_pkg::ERR_OK) begin
      word_nxt.err = chk_word.err_date;
    end else if (day_bad) begin
      word_nxt.err = cdes_pkg::ERR_DAY;
    end else begin
      word_nxt.err = chk_word.err_time;
    end

    year_off   = 13'(chk_word.year - cdes_pkg::EPOCH_YEAR);
    days_years = cdes_pkg::DaysW'({9'd0, year_off} * 22'd365);
    days_leaps = cdes_pkg::DaysW'({10'd0, year_m1[13:2]})
               + cdes_pkg::DaysW'({17'd0, q_y1[6:2]})
               - cdes_pkg::DaysW'({15'd0, q_y1})
               - cdes_pkg::EPOCH_LEAPS;
    days_month = cdes_pkg::DaysW'({13'd0, cdes_pkg::month_start(chk_word.month)})
               + cdes_pkg::DaysW'({21'd0, (chk_word.month > 7'd2) && leap})
               + cdes_pkg::DaysW'({15'd0, chk_word.day})
               - 22'd1;
    word_nxt.days = days_years + days_leaps + days_month;
    word_nxt.tod  = cdes_pkg::TodW'({10'd0, chk_word.hour} * 17'd3600)
                  + cdes_pkg::TodW'({10'd0, chk_word.minute} * 17'd60)
                  + cdes_pkg::TodW'({10'd0, chk_word.second});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= chk_vld;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign day_vld  = vld_r;
  assign day_word = word_r;

endmodule

>>> hw/rtl/cdes_scale.sv
// ----------------------------------------------------------------------------
// cdes_scale: days to seconds
// Third and fourth pipeline stages. Multiplies the day count by the seconds
// of a day, then adds the time of day and zeroes the count on error.
// ----------------------------------------------------------------------------
module cdes_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 day_vld,
  input  cdes_pkg::day_word_t  day_word,
  output logic                 out_vld,
  output cdes_pkg::out_word_t  out_word
);

  logic                               mul_vld_r;
  logic [cdes_pkg::DayMulW-1:0]       mul_r;
  logic [cdes_pkg::TodW-1:0]          tod_r;
  logic [cdes_pkg::ErrW-1:0]          err_r;
  logic                               vld_r;
  cdes_pkg::out_word_t                word_r;
  cdes_pkg::out_word_t                word_nxt;
  logic [cdes_pkg::DayMulW-1:0]       mul_nxt;

  assign mul_nxt = {17'd0, day_word.days} * {22'd0, cdes_pkg::SECS_PER_DAY};

  always_comb begin
    word_nxt.error_code = err_r;
    if (err_r == cdes_pkg::ERR_OK) begin
      word_nxt.epoch_seconds = cdes_pkg::SecsW'(mul_r)
                             + cdes_pkg::SecsW'({21'd0, tod_r});
    end else begin
      word_nxt.epoch_seconds = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      vld_r     <= 1'b0;
    end else begin
      mul_vld_r <= day_vld;
      vld_r     <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    mul_r  <= mul_nxt;
    tod_r  <= day_word.tod;
    err_r  <= day_word.err;
    word_r <= word_nxt;
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule
